// File: hw/rtl/fsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

  localparam int CH_W        = 8;
  localparam int FLAG_W      = 5;
  localparam int OUT_W       = 16;
  localparam int LEN_W       = 3;
  localparam int OUT_MAX     = 65535;
  localparam int NUM_WIDTH_D = 16;

  typedef enum logic [2:0] {
    PH_START,
    PH_FLAGS,
    PH_WIDTH,
    PH_PREC,
    PH_MOD1,
    PH_MOD2,
    PH_MODZJ,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    WS_NONE,
    WS_STAR,
    WS_DIGITS,
    WS_DIGITS_STAR
  } width_status_t;

  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_H    = 3'd1;
  localparam logic [LEN_W-1:0] LEN_HH   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_L    = 3'd3;
  localparam logic [LEN_W-1:0] LEN_LL   = 3'd4;
  localparam logic [LEN_W-1:0] LEN_Z    = 3'd5;
  localparam logic [LEN_W-1:0] LEN_J    = 3'd6;

  typedef struct packed {
    logic [FLAG_W-1:0] flag_mask;
    logic              width_given;
    logic              width_star;
    logic [OUT_W-1:0]  width_value;
    logic              precision_given;
    logic [OUT_W-1:0]  precision_value;
    logic [LEN_W-1:0]  length_code;
    logic [CH_W-1:0]   conversion;
    logic              last_consumed;
    logic              nothing_parsed;
  } result_t;

  // one-hot flag bit: minus, zero, plus, hash, space
  function automatic logic [FLAG_W-1:0] flag_bit(input logic [CH_W-1:0] c);
    logic [FLAG_W-1:0] f;
    f = '0;
    case (c)
      "-":     f = 5'b00001;
      "0":     f = 5'b00010;
      "+":     f = 5'b00100;
      "#":     f = 5'b01000;
      " ":     f = 5'b10000;
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic logic is_plain(input logic [CH_W-1:0] c);
    logic r;
    r = 1'b0;
    case (c)
      "s", "S", "p", "d", "D", "i", "o", "O", "u", "U", "x", "X", "c", "C", "b", "@":
        r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_hl_conv(input logic [CH_W-1:0] c);
    logic r;
    r = 1'b0;
    case (c)
      "d", "D", "i", "o", "O", "u", "U", "x", "X", "p", "c", "C", "s", "S", "b":
        r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_zj_conv(input logic [CH_W-1:0] c);
    logic r;
    r = 1'b0;
    case (c)
      "d", "D", "i", "o", "O", "u", "U", "x", "X", "s", "S", "c", "C", "b":
        r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_mod_run(input logic [CH_W-1:0] c);
    logic r;
    r = 1'b0;
    case (c)
      "h", "l", "j", "z": r = 1'b1;
      default:            r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fsp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fsp_in_if;
  logic                      valid;
  logic                      ready;
  logic [fsp_pkg::CH_W-1:0]  ch;
  logic                      end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fsp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [fsp_pkg::FLAG_W-1:0]   flag_mask;
  logic                         width_given;
  logic                         width_star;
  logic [fsp_pkg::OUT_W-1:0]    width_value;
  logic                         precision_given;
  logic [fsp_pkg::OUT_W-1:0]    precision_value;
  logic [fsp_pkg::LEN_W-1:0]    length_code;
  logic [fsp_pkg::CH_W-1:0]     conversion;
  logic                         last_consumed;
  logic                         nothing_parsed;

  modport source (
    output valid, output flag_mask, output width_given, output width_star,
    output width_value, output precision_given, output precision_value,
    output length_code, output conversion, output last_consumed,
    output nothing_parsed, input ready
  );
  modport sink (
    input valid, input flag_mask, input width_given, input width_star,
    input width_value, input precision_given, input precision_value,
    input length_code, input conversion, input last_consumed,
    input nothing_parsed, output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/format_spec_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Conversion specification parser: feed the characters after a percent sign,
// one per item, with end_of_text marking the terminator. One result item comes
// out per specification (flags, width, precision, length modifier and
// conversion letter); last_consumed tells whether the character that closed
// the record belongs to it, so the caller re-presents it otherwise. Each item
// is decoded in the cycle it is accepted, so the block takes one item per
// clock; a result sits in the output register until taken, and input stalls
// only while that register is full and not being drained. Width and precision
// accumulate in NUM_WIDTH-bit saturating registers and are reported clamped to
// 65535.
module format_spec_parser #(
  parameter int NUM_WIDTH = fsp_pkg::NUM_WIDTH_D
) (
  input  wire          clk,
  input  wire          rst_n,
  fsp_in_if.sink       in_chan,
  fsp_out_if.source    out_chan
);

  localparam int EXT_W = (NUM_WIDTH > fsp_pkg::OUT_W) ? NUM_WIDTH : fsp_pkg::OUT_W;

  fsp_pkg::phase_t                 phase_r, phase_nxt;
  logic [fsp_pkg::FLAG_W-1:0]      flags_r, flags_nxt;
  logic [NUM_WIDTH-1:0]            wacc_r, wacc_nxt;
  fsp_pkg::width_status_t          wstat_r, wstat_nxt;
  logic [NUM_WIDTH-1:0]            pacc_r, pacc_nxt;
  logic                            pseen_r, pseen_nxt;
  logic [fsp_pkg::LEN_W-1:0]       mod_r, mod_nxt;

  fsp_pkg::result_t                res_r, res_nxt;
  logic                            out_valid_r;

  logic                            accept;
  logic                            eot;
  logic [fsp_pkg::CH_W-1:0]        c;
  logic [fsp_pkg::FLAG_W-1:0]      fbit;
  logic                            is_flag, is_star, is_dig, is_dot;
  logic                            is_plain, is_hl, is_zj, is_run;
  logic                            mod_double;

  logic                            emit;
  logic [fsp_pkg::LEN_W-1:0]       emit_len;
  logic [fsp_pkg::CH_W-1:0]        emit_conv;
  logic                            emit_cons;

  function automatic logic [NUM_WIDTH-1:0] acc_step(input logic [NUM_WIDTH-1:0] acc,
                                                     input logic [3:0] d);
    logic [NUM_WIDTH+3:0] v;
    v = ((NUM_WIDTH+4)'(acc) << 3) + ((NUM_WIDTH+4)'(acc) << 1) + (NUM_WIDTH+4)'(d);
    return (|v[NUM_WIDTH+3:NUM_WIDTH]) ? '1 : v[NUM_WIDTH-1:0];
  endfunction

  function automatic logic [fsp_pkg::OUT_W-1:0] clamp_out(input logic [NUM_WIDTH-1:0] acc);
    logic [EXT_W-1:0] e;
    e = EXT_W'(acc);
    return (e > EXT_W'(fsp_pkg::OUT_MAX)) ? '1 : e[fsp_pkg::OUT_W-1:0];
  endfunction

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign eot           = in_chan.end_of_text;
  assign c             = in_chan.ch;

  assign fbit       = fsp_pkg::flag_bit(c);
  assign is_flag    = |fbit;
  assign is_star    = (c == "*");
  assign is_dot     = (c == ".");
  assign is_dig     = (c >= "0") && (c <= "9");
  assign is_plain   = fsp_pkg::is_plain(c);
  assign is_hl      = fsp_pkg::is_hl_conv(c);
  assign is_zj      = fsp_pkg::is_zj_conv(c);
  assign is_run     = fsp_pkg::is_mod_run(c);
  assign mod_double = (mod_r == fsp_pkg::LEN_H && c == "h") ||
                      (mod_r == fsp_pkg::LEN_L && c == "l");

  // next phase and record decision
  always_comb begin
    phase_nxt = phase_r;
    emit      = 1'b0;
    emit_len  = fsp_pkg::LEN_NONE;
    emit_conv = '0;
    emit_cons = 1'b0;
    if (eot) begin
      emit = 1'b1;
    end else begin
      unique case (phase_r)
        fsp_pkg::PH_START, fsp_pkg::PH_FLAGS, fsp_pkg::PH_WIDTH, fsp_pkg::PH_PREC: begin
          if ((phase_r == fsp_pkg::PH_START || phase_r == fsp_pkg::PH_FLAGS) && is_flag) begin
            phase_nxt = fsp_pkg::PH_FLAGS;
          end else if (phase_r != fsp_pkg::PH_PREC && (is_star || is_dig)) begin
            phase_nxt = fsp_pkg::PH_WIDTH;
          end else if (phase_r == fsp_pkg::PH_PREC && is_dig) begin
            phase_nxt = fsp_pkg::PH_PREC;
          end else if (phase_r != fsp_pkg::PH_PREC && is_dot) begin
            phase_nxt = fsp_pkg::PH_PREC;
          end else if (is_plain) begin
            emit      = 1'b1;
            emit_conv = c;
            emit_cons = 1'b1;
          end else if (c == "h" || c == "l") begin
            phase_nxt = fsp_pkg::PH_MOD1;
          end else if (c == "z" || c == "j") begin
            phase_nxt = fsp_pkg::PH_MODZJ;
          end else begin
            emit = 1'b1;
          end
        end
        fsp_pkg::PH_MOD1, fsp_pkg::PH_MOD2, fsp_pkg::PH_MODZJ: begin
          if (phase_r == fsp_pkg::PH_MOD1 && mod_double) begin
            phase_nxt = fsp_pkg::PH_MOD2;
          end else if ((phase_r == fsp_pkg::PH_MODZJ) ? is_zj : is_hl) begin
            emit      = 1'b1;
            emit_len  = mod_r;
            emit_conv = c;
            emit_cons = 1'b1;
          end else if (is_run) begin
            phase_nxt = fsp_pkg::PH_SKIP;
          end else begin
            emit = 1'b1;
          end
        end
        fsp_pkg::PH_SKIP: begin
          if (!is_run) begin
            emit = 1'b1;
          end
        end
        default: phase_nxt = fsp_pkg::PH_START;
      endcase
    end
    if (emit) begin
      phase_nxt = fsp_pkg::PH_START;
    end
  end

  // field registers and the result record
  always_comb begin
    flags_nxt = flags_r;
    wacc_nxt  = wacc_r;
    wstat_nxt = wstat_r;
    pacc_nxt  = pacc_r;
    pseen_nxt = pseen_r;
    mod_nxt   = mod_r;

    res_nxt.flag_mask       = flags_r;
    res_nxt.width_given     = (wstat_r == fsp_pkg::WS_DIGITS) ||
                              (wstat_r == fsp_pkg::WS_DIGITS_STAR);
    res_nxt.width_star      = (wstat_r == fsp_pkg::WS_STAR);
    res_nxt.width_value     = res_nxt.width_given ? clamp_out(wacc_r) : '0;
    res_nxt.precision_given = pseen_r;
    res_nxt.precision_value = pseen_r ? clamp_out(pacc_r) : '0;
    res_nxt.length_code     = emit_len;
    res_nxt.conversion      = emit_conv;
    res_nxt.last_consumed   = emit_cons;
    res_nxt.nothing_parsed  = eot && (phase_r == fsp_pkg::PH_START);

    if (!eot) begin
      case (phase_r)
        fsp_pkg::PH_START, fsp_pkg::PH_FLAGS: begin
          if (is_flag) begin
            flags_nxt = flags_r | fbit;
          end else if (is_star) begin
            wstat_nxt = fsp_pkg::WS_STAR;
          end else if (is_dig) begin
            wstat_nxt = fsp_pkg::WS_DIGITS;
            wacc_nxt  = acc_step('0, c[3:0]);
          end
        end
        fsp_pkg::PH_WIDTH: begin
          if (is_dig && wstat_r == fsp_pkg::WS_DIGITS) begin
            wacc_nxt = acc_step(wacc_r, c[3:0]);
          end else if (is_star && wstat_r == fsp_pkg::WS_DIGITS) begin
            wstat_nxt = fsp_pkg::WS_DIGITS_STAR;
          end
        end
        fsp_pkg::PH_PREC: begin
          if (is_dig) begin
            pacc_nxt = acc_step(pacc_r, c[3:0]);
          end
        end
        fsp_pkg::PH_MOD1: begin
          if (mod_double) begin
            mod_nxt = mod_r + fsp_pkg::LEN_W'(1);
          end
        end
        default: ;
      endcase
      // the dot and modifier start only land in phases that accept them
      if ((phase_r == fsp_pkg::PH_START || phase_r == fsp_pkg::PH_FLAGS ||
           phase_r == fsp_pkg::PH_WIDTH) && is_dot && !is_flag) begin
        pseen_nxt = 1'b1;
      end
      if (phase_nxt == fsp_pkg::PH_MOD1 && phase_r != fsp_pkg::PH_MOD1) begin
        mod_nxt = (c == "h") ? fsp_pkg::LEN_H : fsp_pkg::LEN_L;
      end
      if (phase_nxt == fsp_pkg::PH_MODZJ && phase_r != fsp_pkg::PH_MODZJ) begin
        mod_nxt = (c == "z") ? fsp_pkg::LEN_Z : fsp_pkg::LEN_J;
      end
    end

    if (emit) begin
      flags_nxt = '0;
      wacc_nxt  = '0;
      wstat_nxt = fsp_pkg::WS_NONE;
      pacc_nxt  = '0;
      pseen_nxt = 1'b0;
      mod_nxt   = fsp_pkg::LEN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fsp_pkg::PH_START;
      flags_r     <= '0;
      wacc_r      <= '0;
      wstat_r     <= fsp_pkg::WS_NONE;
      pacc_r      <= '0;
      pseen_r     <= 1'b0;
      mod_r       <= fsp_pkg::LEN_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        flags_r <= flags_nxt;
        wacc_r  <= wacc_nxt;
        wstat_r <= wstat_nxt;
        pacc_r  <= pacc_nxt;
        pseen_r <= pseen_nxt;
        mod_r   <= mod_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.flag_mask       = res_r.flag_mask;
  assign out_chan.width_given     = res_r.width_given;
  assign out_chan.width_star      = res_r.width_star;
  assign out_chan.width_value     = res_r.width_value;
  assign out_chan.precision_given = res_r.precision_given;
  assign out_chan.precision_value = res_r.precision_value;
  assign out_chan.length_code     = res_r.length_code;
  assign out_chan.conversion      = res_r.conversion;
  assign out_chan.last_consumed   = res_r.last_consumed;
  assign out_chan.nothing_parsed  = res_r.nothing_parsed;

endmodule

`default_nettype wire
